/* sv/lbsh_pkg.sv */
// ----------------------------------------------------------------------------
// lbsh_pkg: shared types and constants for the lower-bound search unit
// Op codes, sequencer states, default table depth and the trailing-hole fill.
// ----------------------------------------------------------------------------
`default_nettype none

package lbsh_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int VALUE_W       = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [VALUE_W-1:0] FILL_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/lbsh_ram.sv */
// ----------------------------------------------------------------------------
// lbsh_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/lower_bound_search_with_holes_unit.sv */
// ----------------------------------------------------------------------------
// lower_bound_search_with_holes_unit: lower-bound search over a table with holes
// Loads a non-decreasing signed table (zero is a hole), fills holes on demand
// and answers binary-search lower-bound queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry s_op and s_value: clear, append or
//   query. Clear and append give no result; a query gives one result beat
//   (m_valid/m_ready) with m_position and m_overflow. A query walks one
//   table RAM port with a shared compare, a read then a compare per probe,
//   at most ceil(log2(count+1)) probes. The next beat can be taken in the
//   cycle the result beat rises. The first query after reset, a clear or
//   any append first runs the hole fill, right to left through the RAM,
//   reading each entry and writing the carried value into each hole.
//   s_ready is high only while the sequencer is idle; one item is in work at
//   a time. The result register lets the next item in while a result waits;
//   a second query holds in its final state until the result slot is free.
//   Reset clears the count, the fill and overflow flags and the result valid
//   and returns the sequencer to idle; the table RAM is not cleared, only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module lower_bound_search_with_holes_unit
    import lbsh_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic        [1:0]         s_op,
    input  wire logic signed [VALUE_W-1:0] s_value,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic             [CNT_W-1:0]   m_position,
    output logic                           m_overflow
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      filled_reg, filled_next;
    logic                      dropped_reg, dropped_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [VALUE_W-1:0]        carry_reg, carry_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]          mid_reg, mid_next;
    logic signed [VALUE_W-1:0] needle_reg, needle_next;

    logic                      m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]          m_position_reg, m_position_next;
    logic                      m_overflow_reg, m_overflow_next;

    logic                      ram_wr_en;
    logic [ADDR_W-1:0]         ram_wr_addr;
    logic [VALUE_W-1:0]        ram_wr_data;
    logic                      ram_rd_en;
    logic [ADDR_W-1:0]         ram_rd_addr;
    logic [VALUE_W-1:0]        ram_rd_data;

    logic [CNT_W:0]            mid_sum;
    logic                      in_fire;

    lbsh_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_overflow = m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            filled_reg  <= 1'b0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            filled_reg  <= filled_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        carry_reg      <= carry_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        needle_reg     <= needle_next;
        m_position_reg <= m_position_next;
        m_overflow_reg <= m_overflow_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        filled_next     = filled_reg;
        dropped_next    = dropped_reg;
        idx_next        = idx_reg;
        carry_next      = carry_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        needle_next     = needle_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_position_next = m_position_reg;
        m_overflow_next = m_overflow_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = count_reg[ADDR_W-1:0];
        ram_wr_data     = s_value;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = mid_sum[ADDR_W:1];

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_op)
                        OP_CLEAR: begin
                            count_next   = '0;
                            filled_next  = 1'b0;
                            dropped_next = 1'b0;
                        end
                        OP_APPEND: begin
                            if (count_reg != FULL_COUNT) begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                            filled_next = 1'b0;
                        end
                        OP_QUERY: begin
                            needle_next = s_value;
                            idx_next    = count_reg;
                            carry_next  = FILL_MAX;
                            lo_next     = '0;
                            hi_next     = count_reg;
                            state_next  = filled_reg ? ST_SRCH_RD : ST_FILL_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL_RD: begin
                if (idx_reg == '0) begin
                    filled_next = 1'b1;
                    state_next  = ST_SRCH_RD;
                end else begin
                    idx_next    = idx_reg - 1'b1;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_next[ADDR_W-1:0];
                    state_next  = ST_FILL_WR;
                end
            end
            ST_FILL_WR: begin
                ram_wr_addr = idx_reg[ADDR_W-1:0];
                ram_wr_data = carry_reg;
                if (ram_rd_data == '0) begin
                    ram_wr_en = 1'b1;
                end else begin
                    carry_next = ram_rd_data;
                end
                state_next = ST_FILL_RD;
            end
            ST_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[CNT_W:1];
                    ram_rd_en  = 1'b1;
                    state_next = ST_SRCH_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SRCH_CMP: begin
                if ($signed(ram_rd_data) >= needle_reg) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = ST_SRCH_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_position_next = lo_reg;
                    m_overflow_next = dropped_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH_RD || state_reg == ST_SRCH_CMP)
        |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search window out of range");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_op == OP_QUERY) |=> (state_reg != ST_IDLE && !s_ready))
        else $error("query beat did not start the sequencer");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside final state");

endmodule

`default_nettype wire
